>>> rtl/core/tlpc_pkg.sv
// Shared types, constants and helper functions for the tile layer compositor.
`timescale 1ns / 1ps

package tlpc_pkg;

    localparam int NUM_LAYERS = 5;
    localparam int NUM_BG     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0]  BACKDROP_PRIO = 8'h30;
    localparam logic [7:0]  WIN_FULL_LINE = 8'hE8;
    localparam logic [14:0] WHITE_COLOR   = 15'h7FFF;
    localparam logic [4:0]  MAX_WEIGHT    = 5'd16;
    localparam logic [4:0]  CHAN_MAX      = 5'h1F;

    localparam logic [5:0] BACKDROP_SEL = 6'b100000;

    localparam logic [CFG_IDX_W-1:0] CFG_FORCED_BLANK   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLES = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN0_VERTICAL  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN1_VERTICAL  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_MASKS   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_MASKS  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_CONTROL  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_LEVELS   = 4'd7;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_ALPHA  = 2'd1;
    localparam logic [1:0] MODE_BRIGHT = 2'd2;
    localparam logic [1:0] MODE_DARK   = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ALPHA,
        OP_BRIGHT,
        OP_DARK
    } t_op;

    typedef struct packed {
        logic        forced_blank;
        logic [1:0]  window_enables;
        logic [15:0] win0_vertical;
        logic [15:0] win1_vertical;
        logic [15:0] inside_masks;
        logic [15:0] outside_masks;
        logic [15:0] blend_control;
        logic [20:0] blend_levels;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  prio;
        logic        semi;
        logic [14:0] color;
    } t_layer;

    function automatic logic [4:0] weight_of(input logic [4:0] v);
        return (v > MAX_WEIGHT) ? MAX_WEIGHT : v;
    endfunction

    function automatic logic line_in_window(input logic [15:0] vreg, input logic [7:0] line);
        logic [7:0] top_line;
        logic [7:0] bot_line;
        logic       hit;
        top_line = vreg[15:8];
        bot_line = vreg[7:0];
        if (top_line == bot_line && top_line >= WIN_FULL_LINE) begin
            hit = 1'b1;
        end else if (bot_line >= top_line) begin
            hit = (line >= top_line) && (line < bot_line);
        end else begin
            hit = (line >= top_line) || (line < bot_line);
        end
        return hit;
    endfunction

endpackage

>>> rtl/core/tlpc_front.sv
// Stage 1: window mask selection and per-layer eligibility.
`timescale 1ns / 1ps

module tlpc_front (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  tlpc_pkg::t_cfg                             i_cfg,
    input  tlpc_pkg::t_layer [tlpc_pkg::NUM_LAYERS-1:0] i_layer,
    input  logic                                       i_objwin_hit,
    input  logic                                       i_win0_column_hit,
    input  logic                                       i_win1_column_hit,
    input  logic [7:0]                                 i_line_number,
    input  logic [14:0]                                i_backdrop_color,
    output logic                                       o_valid,
    output tlpc_pkg::t_layer [tlpc_pkg::NUM_LAYERS-1:0] o_layer,
    output logic [tlpc_pkg::NUM_LAYERS-1:0]            o_elig,
    output logic                                       o_fx,
    output logic [14:0]                                o_backdrop
);

    logic [7:0]                          mask;
    logic [tlpc_pkg::NUM_LAYERS-1:0]     elig;

    logic                                r_valid;
    tlpc_pkg::t_layer [tlpc_pkg::NUM_LAYERS-1:0] r_layer;
    logic [tlpc_pkg::NUM_LAYERS-1:0]     r_elig;
    logic                                r_fx;
    logic [14:0]                         r_backdrop;

    always_comb begin
        mask = i_cfg.outside_masks[7:0];
        if (i_objwin_hit) begin
            mask = i_cfg.outside_masks[15:8];
        end
        if (i_cfg.window_enables[1] && i_win1_column_hit &&
            tlpc_pkg::line_in_window(i_cfg.win1_vertical, i_line_number)) begin
            mask = i_cfg.inside_masks[15:8];
        end
        if (i_cfg.window_enables[0] && i_win0_column_hit &&
            tlpc_pkg::line_in_window(i_cfg.win0_vertical, i_line_number)) begin
            mask = i_cfg.inside_masks[7:0];
        end
        for (int i = 0; i < tlpc_pkg::NUM_LAYERS; i++) begin
            elig[i] = mask[i] && (i_layer[i].prio < tlpc_pkg::BACKDROP_PRIO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_layer    <= i_layer;
            r_elig     <= elig;
            r_fx       <= mask[5];
            r_backdrop <= i_backdrop_color;
        end
    end

    assign o_valid    = r_valid;
    assign o_layer    = r_layer;
    assign o_elig     = r_elig;
    assign o_fx       = r_fx;
    assign o_backdrop = r_backdrop;

endmodule

>>> rtl/core/tlpc_rank.sv
// Stages 2 and 3: top and second layer search, effect decision.
`timescale 1ns / 1ps

module tlpc_rank (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  tlpc_pkg::t_cfg                             i_cfg,
    input  tlpc_pkg::t_layer [tlpc_pkg::NUM_LAYERS-1:0] i_layer,
    input  logic [tlpc_pkg::NUM_LAYERS-1:0]            i_elig,
    input  logic                                       i_fx,
    input  logic [14:0]                                i_backdrop,
    output logic                                       o_valid,
    output tlpc_pkg::t_op                              o_op,
    output logic [14:0]                                o_a_color,
    output logic [14:0]                                o_b_color
);

    logic [7:0]  t_prio;
    logic [5:0]  t_oh;
    logic [14:0] t_color;
    logic        t_semi;
    logic [7:0]  k_prio;
    logic [5:0]  k_oh;
    logic [14:0] k_color;

    logic                                r2_valid;
    tlpc_pkg::t_layer [tlpc_pkg::NUM_LAYERS-1:0] r2_layer;
    logic [tlpc_pkg::NUM_LAYERS-1:0]     r2_elig;
    logic                                r2_fx;
    logic [14:0]                         r2_backdrop;
    logic [5:0]                          r2_top_oh;
    logic [14:0]                         r2_top_color;
    logic                                r2_top_semi;
    logic [5:0]                          r2_back_oh;
    logic [14:0]                         r2_back_color;

    logic [7:0]    s_prio;
    logic [5:0]    s_oh;
    logic [14:0]   s_color;
    logic [1:0]    mode;
    logic          first_hit;
    tlpc_pkg::t_op op;
    logic [14:0]   b_color;

    logic          r3_valid;
    tlpc_pkg::t_op r3_op;
    logic [14:0]   r3_a_color;
    logic [14:0]   r3_b_color;

    always_comb begin
        t_prio  = tlpc_pkg::BACKDROP_PRIO;
        t_oh    = tlpc_pkg::BACKDROP_SEL;
        t_color = i_backdrop;
        t_semi  = 1'b0;
        for (int i = 0; i < tlpc_pkg::NUM_LAYERS; i++) begin
            if (i_elig[i] && i_layer[i].prio < t_prio) begin
                t_prio  = i_layer[i].prio;
                t_oh    = 6'(1 << i);
                t_color = i_layer[i].color;
                t_semi  = i_layer[i].semi;
            end
        end
        k_prio  = tlpc_pkg::BACKDROP_PRIO;
        k_oh    = tlpc_pkg::BACKDROP_SEL;
        k_color = i_backdrop;
        for (int i = 0; i < tlpc_pkg::NUM_BG; i++) begin
            if (i_elig[i] && i_layer[i].prio < k_prio) begin
                k_prio  = i_layer[i].prio;
                k_oh    = 6'(1 << i);
                k_color = i_layer[i].color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_layer      <= i_layer;
            r2_elig       <= i_elig;
            r2_fx         <= i_fx;
            r2_backdrop   <= i_backdrop;
            r2_top_oh     <= t_oh;
            r2_top_color  <= t_color;
            r2_top_semi   <= t_semi;
            r2_back_oh    <= k_oh;
            r2_back_color <= k_color;
        end
    end

    always_comb begin
        s_prio  = tlpc_pkg::BACKDROP_PRIO;
        s_oh    = tlpc_pkg::BACKDROP_SEL;
        s_color = r2_backdrop;
        for (int i = 0; i < tlpc_pkg::NUM_LAYERS; i++) begin
            if (r2_elig[i] && !r2_top_oh[i] && r2_layer[i].prio < s_prio) begin
                s_prio  = r2_layer[i].prio;
                s_oh    = 6'(1 << i);
                s_color = r2_layer[i].color;
            end
        end

        mode      = i_cfg.blend_control[7:6];
        first_hit = |(r2_top_oh & i_cfg.blend_control[5:0]);
        op        = tlpc_pkg::OP_NONE;
        b_color   = r2_back_color;
        if (r2_top_semi) begin
            if (|(r2_back_oh & i_cfg.blend_control[13:8])) begin
                op = tlpc_pkg::OP_ALPHA;
            end else if (first_hit && mode == tlpc_pkg::MODE_BRIGHT) begin
                op = tlpc_pkg::OP_BRIGHT;
            end else if (first_hit && mode == tlpc_pkg::MODE_DARK) begin
                op = tlpc_pkg::OP_DARK;
            end
        end else if (r2_fx && first_hit) begin
            unique case (mode)
                tlpc_pkg::MODE_ALPHA: begin
                    b_color = s_color;
                    if (|(s_oh & i_cfg.blend_control[13:8])) begin
                        op = tlpc_pkg::OP_ALPHA;
                    end
                end
                tlpc_pkg::MODE_BRIGHT: op = tlpc_pkg::OP_BRIGHT;
                tlpc_pkg::MODE_DARK:   op = tlpc_pkg::OP_DARK;
                default:               op = tlpc_pkg::OP_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_op      <= op;
            r3_a_color <= r2_top_color;
            r3_b_color <= b_color;
        end
    end

    assign o_valid   = r3_valid;
    assign o_op      = r3_op;
    assign o_a_color = r3_a_color;
    assign o_b_color = r3_b_color;

endmodule

>>> rtl/core/tlpc_blend.sv
// Stages 4 and 5: per-channel weight products, then alpha/brighten/darken (or forced-blank white) and output.
`timescale 1ns / 1ps

module tlpc_blend (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tlpc_pkg::t_cfg i_cfg,
    input  tlpc_pkg::t_op  i_op,
    input  logic [14:0]    i_a_color,
    input  logic [14:0]    i_b_color,
    output logic           o_valid,
    output logic [14:0]    o_color
);

    localparam int NUM_CH = 3;
    localparam int CH_W   = 5;

    logic [4:0] wa;
    logic [4:0] wb;
    logic [4:0] wy;

    logic [9:0] sum [NUM_CH];
    logic [9:0] up  [NUM_CH];
    logic [9:0] dn  [NUM_CH];

    logic          r4_valid;
    tlpc_pkg::t_op r4_op;
    logic [14:0]   r4_a;
    logic [9:0]    r4_sum [NUM_CH];
    logic [9:0]    r4_up  [NUM_CH];
    logic [9:0]    r4_dn  [NUM_CH];

    logic [5:0]  alpha_raw [NUM_CH];
    logic [14:0] mix;
    logic [14:0] n_color;

    logic        r_valid;
    logic [14:0] r_color;

    assign wa = tlpc_pkg::weight_of(i_cfg.blend_levels[4:0]);
    assign wb = tlpc_pkg::weight_of(i_cfg.blend_levels[12:8]);
    assign wy = tlpc_pkg::weight_of(i_cfg.blend_levels[20:16]);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sum[c] = {5'd0, i_a_color[c*CH_W +: CH_W]} * {5'd0, wa}
                   + {5'd0, i_b_color[c*CH_W +: CH_W]} * {5'd0, wb};
            up[c]  = {5'd0, tlpc_pkg::CHAN_MAX - i_a_color[c*CH_W +: CH_W]} * {5'd0, wy};
            dn[c]  = {5'd0, i_a_color[c*CH_W +: CH_W]} * {5'd0, wy};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_op  <= i_op;
            r4_a   <= i_a_color;
            r4_sum <= sum;
            r4_up  <= up;
            r4_dn  <= dn;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            alpha_raw[c] = r4_sum[c][9:4];
            case (r4_op)
                tlpc_pkg::OP_ALPHA:
                    mix[c*CH_W +: CH_W] = (alpha_raw[c] > {1'b0, tlpc_pkg::CHAN_MAX}) ?
                                          tlpc_pkg::CHAN_MAX : alpha_raw[c][4:0];
                tlpc_pkg::OP_BRIGHT:
                    mix[c*CH_W +: CH_W] = r4_a[c*CH_W +: CH_W] + r4_up[c][8:4];
                tlpc_pkg::OP_DARK:
                    mix[c*CH_W +: CH_W] = r4_a[c*CH_W +: CH_W] - r4_dn[c][8:4];
                default:
                    mix[c*CH_W +: CH_W] = r4_a[c*CH_W +: CH_W];
            endcase
        end
        n_color = i_cfg.forced_blank ? tlpc_pkg::WHITE_COLOR : mix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_color <= n_color;
        end
    end

    assign o_valid = r_valid;
    assign o_color = r_color;

endmodule

>>> rtl/core/tile_layer_priority_compositor_unit.sv
// Top level of the tile layer priority compositor: config registers and pipeline.
//
// Usage:
//   Pixel requests enter on i_valid/o_ready with four background words, the
//   sprite word, window hit flags, line number and backdrop color. Each request
//   yields one 15-bit color on o_valid/i_ready.
//   Configuration registers are written through i_cfg_valid/o_cfg_ready with a
//   register index and data; o_cfg_ready is always high. Write only while no
//   pixel is in flight.
//   Pipeline: five register stages.
//   Throughput: one pixel per cycle while the output is not stalled. The path
//   is mask select, top-layer search, second-layer search, weight products,
//   then blend and clamp.
//   Stall: when o_valid is high and i_ready low, every stage holds and o_ready
//   drops; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties the pipeline and clears all
//   configuration registers to zero.
`timescale 1ns / 1ps

module tile_layer_priority_compositor_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [31:0]                       i_bg0_word,
    input  logic [31:0]                       i_bg1_word,
    input  logic [31:0]                       i_bg2_word,
    input  logic [31:0]                       i_bg3_word,
    input  logic [31:0]                       i_sprite_word,
    input  logic                              i_objwin_hit,
    input  logic                              i_win0_column_hit,
    input  logic                              i_win1_column_hit,
    input  logic [7:0]                        i_line_number,
    input  logic [14:0]                       i_backdrop_color,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [14:0]                       o_mixed_color,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tlpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tlpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tlpc_pkg::t_cfg r_cfg;
    logic           en;

    logic [31:0]                                 words [tlpc_pkg::NUM_LAYERS];
    tlpc_pkg::t_layer [tlpc_pkg::NUM_LAYERS-1:0] layer_in;

    logic                                        s1_valid;
    tlpc_pkg::t_layer [tlpc_pkg::NUM_LAYERS-1:0] s1_layer;
    logic [tlpc_pkg::NUM_LAYERS-1:0]             s1_elig;
    logic                                        s1_fx;
    logic [14:0]                                 s1_backdrop;

    logic          s3_valid;
    tlpc_pkg::t_op s3_op;
    logic [14:0]   s3_a_color;
    logic [14:0]   s3_b_color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tlpc_pkg::CFG_FORCED_BLANK:   r_cfg.forced_blank   <= i_cfg_data[0];
                tlpc_pkg::CFG_WINDOW_ENABLES: r_cfg.window_enables <= i_cfg_data[1:0];
                tlpc_pkg::CFG_WIN0_VERTICAL:  r_cfg.win0_vertical  <= i_cfg_data[15:0];
                tlpc_pkg::CFG_WIN1_VERTICAL:  r_cfg.win1_vertical  <= i_cfg_data[15:0];
                tlpc_pkg::CFG_INSIDE_MASKS:   r_cfg.inside_masks   <= i_cfg_data[15:0];
                tlpc_pkg::CFG_OUTSIDE_MASKS:  r_cfg.outside_masks  <= i_cfg_data[15:0];
                tlpc_pkg::CFG_BLEND_CONTROL:  r_cfg.blend_control  <= i_cfg_data[15:0];
                tlpc_pkg::CFG_BLEND_LEVELS:   r_cfg.blend_levels   <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    // advance every stage unless the output holds an untaken result
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    assign words[0] = i_bg0_word;
    assign words[1] = i_bg1_word;
    assign words[2] = i_bg2_word;
    assign words[3] = i_bg3_word;
    assign words[4] = i_sprite_word;

    always_comb begin
        for (int i = 0; i < tlpc_pkg::NUM_LAYERS; i++) begin
            layer_in[i].prio  = words[i][31:24];
            layer_in[i].semi  = words[i][16];
            layer_in[i].color = words[i][14:0];
        end
    end

    tlpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (i_valid),
        .i_cfg             (r_cfg),
        .i_layer           (layer_in),
        .i_objwin_hit      (i_objwin_hit),
        .i_win0_column_hit (i_win0_column_hit),
        .i_win1_column_hit (i_win1_column_hit),
        .i_line_number     (i_line_number),
        .i_backdrop_color  (i_backdrop_color),
        .o_valid           (s1_valid),
        .o_layer           (s1_layer),
        .o_elig            (s1_elig),
        .o_fx              (s1_fx),
        .o_backdrop        (s1_backdrop)
    );

    tlpc_rank u_rank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s1_valid),
        .i_cfg      (r_cfg),
        .i_layer    (s1_layer),
        .i_elig     (s1_elig),
        .i_fx       (s1_fx),
        .i_backdrop (s1_backdrop),
        .o_valid    (s3_valid),
        .o_op       (s3_op),
        .o_a_color  (s3_a_color),
        .o_b_color  (s3_b_color)
    );

    tlpc_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (s3_valid),
        .i_cfg     (r_cfg),
        .i_op      (s3_op),
        .i_a_color (s3_a_color),
        .i_b_color (s3_b_color),
        .o_valid   (o_valid),
        .o_color   (o_mixed_color)
    );

endmodule

>>> rtl/core/tlpc_checker.sv
// Port-level checks for the compositor top level, with bind.
`timescale 1ns / 1ps

module tlpc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [14:0]                     o_mixed_color,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mixed_color))
        else $error("result changed while stalled");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_ready_when_free: assert property (@(posedge i_clk)
        !o_valid || i_ready |-> o_ready)
        else $error("input blocked while output free");

    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while pipeline stalled");

    a_cfg_always_ready: assert property (@(posedge i_clk)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind tile_layer_priority_compositor_unit tlpc_checker u_tlpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_mixed_color (o_mixed_color),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);
